// ===== hw/rtl/sdsf_pkg.sv =====
// Shared types, limits and the digit pattern table of the signed decimal
// seven-segment formatter. No dependencies.
package sdsf_pkg;

    localparam int MagWidth = 14;
    localparam int DigWidth = 4;
    localparam int SegWidth = 7;
    localparam int NumPos   = 4;

    localparam logic signed [15:0] MODE0_MAX = 16'sd9999;
    localparam logic signed [15:0] MODE0_MIN = -16'sd999;
    localparam logic signed [15:0] MODE1_MAX = 16'sd999;
    localparam logic signed [15:0] MODE1_MIN = -16'sd99;

    localparam logic [SegWidth-1:0] SEG_MINUS = 7'h40;
    localparam logic [SegWidth-1:0] SEG_BLANK = 7'h00;

    localparam logic MODE_DECIMAL = 1'b0;
    localparam logic MODE_INTEGER = 1'b1;

    typedef struct packed {
        logic blank;
        logic mode;
        logic neg;
        logic dashes;
    } ctl_t;

    typedef struct packed {
        ctl_t                ctl;
        logic [MagWidth-1:0] mag;
    } mag_t;

    typedef struct packed {
        ctl_t       ctl;
        logic [6:0] hi;
        logic [6:0] lo;
    } pair_t;

    typedef struct packed {
        ctl_t                              ctl;
        logic [NumPos-1:0][DigWidth-1:0]   dig;
    } digits_t;

    typedef struct packed {
        logic [NumPos-1:0][SegWidth-1:0] seg;
        logic                            point;
    } display_t;

    function automatic logic [SegWidth-1:0] digit_pattern(input logic [DigWidth-1:0] d);
        logic [SegWidth-1:0] p;
        case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/sdsf_clamp.sv =====
// First pipeline stage: clamps the value to the mode's range and splits it
// into sign and magnitude. Depends on sdsf_pkg.
module sdsf_clamp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic signed [15:0]  value,
    input  logic                blank,
    input  logic                dash_on_zero,
    output logic                out_valid,
    input  logic                out_ready,
    output sdsf_pkg::mag_t      out_data
);
    import sdsf_pkg::*;

    logic              valid_reg;
    mag_t              data_reg;
    mag_t              data_next;
    logic signed [15:0] hi_lim;
    logic signed [15:0] lo_lim;
    logic signed [15:0] clamped;
    logic signed [15:0] negated;

    always_comb begin
        hi_lim = (mode == MODE_INTEGER) ? MODE1_MAX : MODE0_MAX;
        lo_lim = (mode == MODE_INTEGER) ? MODE1_MIN : MODE0_MIN;
        if (value > hi_lim) begin
            clamped = hi_lim;
        end else if (value < lo_lim) begin
            clamped = lo_lim;
        end else begin
            clamped = value;
        end
        negated              = -clamped;
        data_next.ctl.blank  = blank;
        data_next.ctl.mode   = mode;
        data_next.ctl.neg    = clamped[15];
        data_next.ctl.dashes = (mode == MODE_INTEGER) && (value == 16'sd0) && dash_on_zero;
        data_next.mag        = clamped[15] ? negated[MagWidth-1:0] : clamped[MagWidth-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/sdsf_split100.sv =====
// Second pipeline stage: splits the magnitude into hundreds and remainder by a
// reciprocal multiplication. Depends on sdsf_pkg.
module sdsf_split100 (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sdsf_pkg::mag_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sdsf_pkg::pair_t  out_data
);
    import sdsf_pkg::*;

    localparam logic [12:0] Recip100 = 13'd5243;

    logic        valid_reg;
    pair_t       data_reg;
    pair_t       data_next;
    logic [26:0] prod;
    logic [6:0]  quot;
    logic [13:0] times100;
    logic [13:0] rem;

    always_comb begin
        prod      = 27'(in_data.mag) * 27'(Recip100);
        quot      = prod[25:19];
        times100  = (14'(quot) << 6) + (14'(quot) << 5) + (14'(quot) << 2);
        rem       = in_data.mag - times100;
        data_next.ctl = in_data.ctl;
        data_next.hi  = quot;
        data_next.lo  = rem[6:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/sdsf_split10.sv =====
// Third pipeline stage: splits both two-digit halves into tens and ones,
// giving the four decimal digits. Depends on sdsf_pkg.
module sdsf_split10 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdsf_pkg::pair_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sdsf_pkg::digits_t  out_data
);
    import sdsf_pkg::*;

    localparam logic [6:0] Recip10 = 7'd103;

    logic        valid_reg;
    digits_t     data_reg;
    digits_t     data_next;
    logic [13:0] prod_hi;
    logic [13:0] prod_lo;
    logic [3:0]  tens_hi;
    logic [3:0]  tens_lo;
    logic [6:0]  ones_hi;
    logic [6:0]  ones_lo;

    always_comb begin
        prod_hi = 14'(in_data.hi) * 14'(Recip10);
        prod_lo = 14'(in_data.lo) * 14'(Recip10);
        tens_hi = prod_hi[13:10];
        tens_lo = prod_lo[13:10];
        ones_hi = in_data.hi - ((7'(tens_hi) << 3) + (7'(tens_hi) << 1));
        ones_lo = in_data.lo - ((7'(tens_lo) << 3) + (7'(tens_lo) << 1));
        data_next.ctl    = in_data.ctl;
        data_next.dig[0] = tens_hi;
        data_next.dig[1] = ones_hi[DigWidth-1:0];
        data_next.dig[2] = tens_lo;
        data_next.dig[3] = ones_lo[DigWidth-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/sdsf_seg.sv =====
// Last pipeline stage and output register: places digits, leading zero,
// minus sign, dashes and blanking into segment patterns. Depends on sdsf_pkg.
module sdsf_seg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdsf_pkg::digits_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdsf_pkg::display_t  out_data
);
    import sdsf_pkg::*;

    logic     valid_reg;
    display_t data_reg;
    display_t data_next;
    logic [2:0] sig_cnt;
    logic [2:0] shown;

    always_comb begin
        if (in_data.dig[0] != '0) begin
            sig_cnt = 3'd4;
        end else if (in_data.dig[1] != '0) begin
            sig_cnt = 3'd3;
        end else if (in_data.dig[2] != '0) begin
            sig_cnt = 3'd2;
        end else begin
            sig_cnt = 3'd1;
        end
        // A single significant digit in decimal mode gets a leading zero.
        if (in_data.ctl.mode == MODE_DECIMAL && sig_cnt == 3'd1) begin
            shown = 3'd2;
        end else begin
            shown = sig_cnt;
        end

        data_next.point = !in_data.ctl.blank && (in_data.ctl.mode == MODE_DECIMAL);
        for (int i = 0; i < NumPos; i++) begin
            if (in_data.ctl.blank) begin
                data_next.seg[i] = SEG_BLANK;
            end else if (in_data.ctl.dashes) begin
                data_next.seg[i] = (i == 0) ? SEG_BLANK : SEG_MINUS;
            end else if (3'(i) >= 3'(NumPos) - shown) begin
                data_next.seg[i] = digit_pattern(in_data.dig[i]);
            end else if (in_data.ctl.neg && (3'(i) == 3'(NumPos - 1) - shown)) begin
                data_next.seg[i] = SEG_MINUS;
            end else begin
                data_next.seg[i] = SEG_BLANK;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/signed_decimal_seven_segment_formatter_top.sv =====
// Each accepted input item is registered in every stage in turn before its result is on the m_ port.
// Throughput: one item per cycle while m_ready is high, through a four-stage pipeline (clamp,
// split by hundred, split by ten, segment build) with valid bits in every stage.
// Reset: synchronous, active-low aresetn clears all stage valid bits.
// Depends on sdsf_pkg and the sdsf stage modules.
module signed_decimal_seven_segment_formatter_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic signed [15:0] s_value,
    input  logic               s_blank,
    input  logic               s_dash_on_zero,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_seg_first,
    output logic [6:0]         m_seg_second,
    output logic [6:0]         m_seg_third,
    output logic [6:0]         m_seg_fourth,
    output logic               m_point_on
);
    import sdsf_pkg::*;

    logic     v1;
    logic     r1;
    mag_t     d1;
    logic     v2;
    logic     r2;
    pair_t    d2;
    logic     v3;
    logic     r3;
    digits_t  d3;
    display_t d4;

    sdsf_clamp u_clamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .mode         (s_mode),
        .value        (s_value),
        .blank        (s_blank),
        .dash_on_zero (s_dash_on_zero),
        .out_valid    (v1),
        .out_ready    (r1),
        .out_data     (d1)
    );

    sdsf_split100 u_split100 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    sdsf_split10 u_split10 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (d2),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    sdsf_seg u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_data   (d3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (d4)
    );

    assign m_seg_first  = d4.seg[0];
    assign m_seg_second = d4.seg[1];
    assign m_seg_third  = d4.seg[2];
    assign m_seg_fourth = d4.seg[3];
    assign m_point_on   = d4.point;

`ifndef SYNTHESIS
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the output side can move");

    a_point_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_point_on) |-> (m_seg_fourth != SEG_BLANK))
        else $error("decimal item without a rightmost digit");

    a_first_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_seg_first != SEG_BLANK)) |-> m_point_on)
        else $error("leftmost position lit outside decimal mode");
`endif

endmodule

// ===== verif/signed_decimal_seven_segment_formatter_checker.sv =====
// Checker for the signed decimal seven-segment formatter: watches both channels,
// predicts each display from the accepted input item and compares it field by field.
// Depends on sdsf_pkg.
module signed_decimal_seven_segment_formatter_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_mode,
    input  logic signed [15:0] s_value,
    input  logic               s_blank,
    input  logic               s_dash_on_zero,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [6:0]         m_seg_first,
    input  logic [6:0]         m_seg_second,
    input  logic [6:0]         m_seg_third,
    input  logic [6:0]         m_seg_fourth,
    input  logic               m_point_on,
    output int                 fail_count,
    output int                 pending,
    output int                 compared
);
    import sdsf_pkg::*;

    typedef struct packed {
        logic [SegWidth-1:0] first;
        logic [SegWidth-1:0] second;
        logic [SegWidth-1:0] third;
        logic [SegWidth-1:0] fourth;
        logic                point;
    } readout_t;

    localparam logic [9:0][SegWidth-1:0] DigitSeg = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    readout_t expected_readouts[$];
    int       compared_n = 0;

    function automatic readout_t format_display(input logic mode,
                                                input logic signed [15:0] value,
                                                input logic blank,
                                                input logic dash);
        readout_t            r;
        logic [SegWidth-1:0] seg [4];
        int                  v;
        int                  mag;
        int                  pos;
        int                  lowest;
        logic                neg;
        r = '0;
        for (int i = 0; i < 4; i++) seg[i] = SEG_BLANK;
        v = int'(value);
        if (!blank) begin
            if (mode == MODE_DECIMAL) begin
                if (v > int'(MODE0_MAX)) v = int'(MODE0_MAX);
                if (v < int'(MODE0_MIN)) v = int'(MODE0_MIN);
                r.point = 1'b1;
            end else begin
                if (v > int'(MODE1_MAX)) v = int'(MODE1_MAX);
                if (v < int'(MODE1_MIN)) v = int'(MODE1_MIN);
            end
            neg = (v < 0);
            mag = neg ? -v : v;
            lowest = (mode == MODE_INTEGER) ? 1 : 0;
            pos = 3;
            if (mode == MODE_INTEGER && mag == 0 && dash) begin
                seg[1] = SEG_MINUS;
                seg[2] = SEG_MINUS;
                seg[3] = SEG_MINUS;
            end else begin
                do begin
                    if (pos >= lowest) seg[pos] = DigitSeg[mag % 10];
                    mag = mag / 10;
                    pos--;
                end while (mag != 0);
                // A single significant digit in decimal mode still shows "0.x".
                if (mode == MODE_DECIMAL && pos == 2) begin
                    seg[2] = DigitSeg[0];
                    pos--;
                end
                if (neg && pos >= lowest) seg[pos] = SEG_MINUS;
            end
        end
        r.first  = seg[0];
        r.second = seg[1];
        r.third  = seg[2];
        r.fourth = seg[3];
        return r;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at display %0d: %s", compared_n, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [SegWidth-1:0] got,
                               input logic [SegWidth-1:0] want);
        if (got !== want) begin
            report($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : watch
        readout_t want;
        if (!aresetn) begin
            expected_readouts.delete();
            fail_count = 0;
            compared_n = 0;
            pending  <= 0;
            compared <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_readouts.push_back(
                    format_display(s_mode, s_value, s_blank, s_dash_on_zero));
            end
            if (m_valid && m_ready) begin
                if (expected_readouts.size() == 0) begin
                    report("display item arrived with no input item waiting");
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("seg_first", m_seg_first, want.first);
                    check_field("seg_second", m_seg_second, want.second);
                    check_field("seg_third", m_seg_third, want.third);
                    check_field("seg_fourth", m_seg_fourth, want.fourth);
                    check_field("point_on", SegWidth'(m_point_on), SegWidth'(want.point));
                end
                compared_n++;
            end
            pending  <= expected_readouts.size();
            compared <= compared_n;
        end
    end

endmodule

// ===== verif/signed_decimal_seven_segment_formatter_top_test.sv =====
// Testbench top for the signed decimal seven-segment formatter: drives directed and
// random input items with random gaps and output stalls, and gives the verdict.
// Depends on sdsf_pkg, the formatter RTL and signed_decimal_seven_segment_formatter_checker.
module signed_decimal_seven_segment_formatter_top_test;
    import sdsf_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int RandomItems = 1525;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic signed [15:0] s_value;
    logic               s_blank;
    logic               s_dash_on_zero;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [6:0]         m_seg_first;
    logic [6:0]         m_seg_second;
    logic [6:0]         m_seg_third;
    logic [6:0]         m_seg_fourth;
    logic               m_point_on;
    int                 fail_count;
    int                 pending;
    int                 compared;

    int cycles      = 0;
    int sent        = 0;
    int sent_int    = 0;
    int sent_blank  = 0;
    bit steady      = 1'b0;
    int stall_left  = 0;
    int sink_phase  = 0;
    bit sink_steady = 1'b0;

    signed_decimal_seven_segment_formatter_top dut (.*);

    signed_decimal_seven_segment_formatter_checker display_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles with %0d displays outstanding", cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // The receiver alternates between stretches of random stalls and stretches
    // in which it is always ready.
    always @(posedge aclk) begin
        if (sink_phase == 0) begin
            sink_steady = ($urandom_range(0, 3) == 0);
            sink_phase = $urandom_range(50, 300);
        end
        sink_phase--;
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!sink_steady) stall_left = idle_length();
        end
    end

    function automatic logic signed [15:0] pick_value(input logic mode);
        int r;
        int lo;
        int hi;
        int base;
        lo = (mode == MODE_INTEGER) ? int'(MODE1_MIN) : int'(MODE0_MIN);
        hi = (mode == MODE_INTEGER) ? int'(MODE1_MAX) : int'(MODE0_MAX);
        r = $urandom_range(0, 99);
        if (r < 40) return 16'($urandom);
        if (r < 70) return 16'(lo + int'($urandom_range(0, hi - lo)));
        if (r < 85) return 16'(int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 6))
            0:       base = lo;
            1:       base = hi;
            2:       base = 10;
            3:       base = -10;
            4:       base = 100;
            5:       base = -100;
            default: base = 1000;
        endcase
        return 16'(base + int'($urandom_range(0, 4)) - 2);
    endfunction

    task automatic send_item(input logic mode, input logic signed [15:0] value,
                             input logic blank, input logic dash);
        int gap;
        gap = steady ? 0 : idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_value        <= value;
        s_blank        <= blank;
        s_dash_on_zero <= dash;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (mode == MODE_INTEGER) sent_int++;
        if (blank) sent_blank++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic mode;
        logic blank;
        logic dash;
        s_valid        <= 1'b0;
        s_mode         <= MODE_DECIMAL;
        s_value        <= '0;
        s_blank        <= 1'b0;
        s_dash_on_zero <= 1'b0;
        aresetn        <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Decimal mode: zero, single digits, saturation at both ends and the
        // dash flag that this mode ignores.
        send_item(MODE_DECIMAL, 16'sd0, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd5, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, -16'sd5, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, -16'sd12, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd123, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd1234, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd9999, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd10000, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sh7FFF, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, -16'sd999, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, -16'sd1000, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sh8000, 1'b0, 1'b0);
        send_item(MODE_DECIMAL, 16'sd0, 1'b0, 1'b1);
        // Integer mode: single zero, dashes, saturation and signs.
        send_item(MODE_INTEGER, 16'sd0, 1'b0, 1'b0);
        send_item(MODE_INTEGER, 16'sd0, 1'b0, 1'b1);
        send_item(MODE_INTEGER, 16'sd999, 1'b0, 1'b0);
        send_item(MODE_INTEGER, 16'sd1000, 1'b0, 1'b1);
        send_item(MODE_INTEGER, -16'sd99, 1'b0, 1'b0);
        send_item(MODE_INTEGER, -16'sd100, 1'b0, 1'b0);
        send_item(MODE_INTEGER, 16'sd7, 1'b0, 1'b1);
        send_item(MODE_INTEGER, -16'sd7, 1'b0, 1'b0);
        send_item(MODE_INTEGER, 16'sh8000, 1'b0, 1'b1);
        send_item(MODE_INTEGER, 16'sd50, 1'b0, 1'b0);
        // Blanking overrides everything, in both modes.
        send_item(MODE_DECIMAL, 16'sd1234, 1'b1, 1'b0);
        send_item(MODE_INTEGER, 16'sd0, 1'b1, 1'b1);
        wait_for_drain();

        for (int n = 0; n < RandomItems; n++) begin
            if (n % 120 == 0) steady = ($urandom_range(0, 3) == 0);
            if (n == RandomItems / 2) wait_for_drain();
            mode  = 1'($urandom_range(0, 1));
            blank = ($urandom_range(0, 9) == 0);
            dash  = 1'($urandom_range(0, 1));
            send_item(mode, pick_value(mode), blank, dash);
        end
        wait_for_drain();
        repeat (12) @(posedge aclk);

        $display("Sent %0d items (%0d integer mode, %0d blanked): directed extremes, then",
                 sent, sent_int, sent_blank);
        $display("random values with saturation and digit-count boundaries; %0d displays compared",
                 compared);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdsf_pkg.sv
hw/rtl/sdsf_clamp.sv
hw/rtl/sdsf_split100.sv
hw/rtl/sdsf_split10.sv
hw/rtl/sdsf_seg.sv
hw/rtl/signed_decimal_seven_segment_formatter_top.sv
verif/signed_decimal_seven_segment_formatter_checker.sv
verif/signed_decimal_seven_segment_formatter_top_test.sv
